### hdl/swph_pkg.sv
package swph_pkg;

    localparam int CellSlots = 26;

    typedef struct packed {
        logic        func;
        logic        pair_valid;
        logic [27:0] span_hi;
        logic [27:0] span_lo;
        logic [5:0]  pair_type;
        logic        mei_on_first;
        logic [11:0] read_cell;
        logic [1:0]  read_group;
        logic [2:0]  read_slot;
    } in_item_t;

    typedef struct packed {
        logic [31:0] count_value;
        logic        cell_touched;
    } out_item_t;

    typedef enum logic {
        FUNC_ADD  = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef enum logic {
        CFG_WINDOW = 1'b0,
        CFG_STEP   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_DIV_HI,
        FR_DIV_LO,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RD,
        BK_WAIT,
        BK_WR,
        BK_OUT
    } back_state_t;

    // Front to back command: window range and slot offsets
    typedef struct packed {
        logic        is_read;
        logic [31:0] first;
        logic [31:0] last;
        logic        proper;
        logic [4:0]  off0;
        logic [4:0]  off1;
        logic [4:0]  off2;
        logic [11:0] read_cell;
        logic [1:0]  read_group;
        logic [2:0]  read_slot;
    } cmd_t;

    function automatic logic [4:0] slot_off(input logic [1:0] g, input logic [5:0] t,
                                            input logic mf);
        logic [2:0] s;
        s = {mf, t[g + 3'd2], t[2]};
        return 5'd2 + 5'({g - 2'd1, 3'b000}) + 5'(s);
    endfunction

endpackage

### hdl/swph_front.sv
module swph_front (
    input  logic               clk,
    input  logic               rst_n,
    input  swph_pkg::in_item_t in_item,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        window_length,
    input  logic [15:0]        step_length,
    output swph_pkg::cmd_t     cmd,
    output logic               cmd_valid,
    input  logic               cmd_ready
);
    import swph_pkg::*;

    front_state_t state_reg, state_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        which_reg, which_next;
    logic        zero_reg, zero_next;
    logic [31:0] first_reg, first_next;
    cmd_t        cmd_reg, cmd_next;
    logic [15:0] win, step;
    logic [17:0] trial;

    assign win  = (window_length == 16'd0) ? 16'd1 : window_length;
    assign step = (step_length == 16'd0) ? 16'd1 : step_length;
    assign trial = {rem_reg, num_reg[31]} - {2'b00, step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        which_reg <= which_next;
        zero_reg  <= zero_next;
        first_reg <= first_next;
        cmd_reg   <= cmd_next;
    end

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        which_next = which_reg;
        zero_next  = zero_reg;
        first_next = first_reg;
        cmd_next   = cmd_reg;
        in_ready   = 1'b0;
        cmd_valid  = 1'b0;
        unique case (state_reg) inside
            FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next.is_read    = (in_item.func == FUNC_READ);
                    cmd_next.read_cell  = in_item.read_cell;
                    cmd_next.read_group = in_item.read_group;
                    cmd_next.read_slot  = in_item.read_slot;
                    cmd_next.proper     = (in_item.pair_type <= 6'd2);
                    cmd_next.off0       = (in_item.pair_type == 6'd0) ? 5'd0 :
                        (in_item.pair_type <= 6'd2) ? 5'd1 :
                        slot_off(2'd1, in_item.pair_type, in_item.mei_on_first);
                    cmd_next.off1 = slot_off(2'd2, in_item.pair_type, in_item.mei_on_first);
                    cmd_next.off2 = slot_off(2'd3, in_item.pair_type, in_item.mei_on_first);
                    cmd_next.first = 32'd1;
                    cmd_next.last  = 32'd0;
                    if (in_item.func == FUNC_READ)
                    begin
                        state_next = FR_PUSH;
                    end
                    else if (in_item.pair_valid)
                    begin
                        zero_next = 1'b0;
                        if ({4'd0, in_item.span_hi} >= {16'd0, win})
                        begin
                            num_next = {4'd0, in_item.span_hi} - {16'd0, win};
                        end
                        else
                        begin
                            num_next = {16'd0, win} - {4'd0, in_item.span_hi};
                            zero_next = 1'b1;
                        end
                        which_next = 1'b0;
                        rem_next   = 17'd0;
                        quo_next   = 32'd0;
                        cnt_next   = 6'd0;
                        first_next = {4'd0, in_item.span_lo};
                        state_next = FR_DIV_HI;
                    end
                end
            end
            FR_DIV_HI, FR_DIV_LO:
            begin
                // restoring division, one bit per cycle
                if (!trial[17])
                begin
                    rem_next = trial[16:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[15:0], num_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                num_next = {num_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    if (!which_reg)
                    begin
                        if (zero_reg)
                        begin
                            cmd_next.first = (quo_next != 32'd0) ? 32'd0 : 32'd1;
                        end
                        else
                        begin
                            cmd_next.first = quo_next + 32'd1;
                        end
                        num_next   = first_reg;
                        rem_next   = 17'd0;
                        quo_next   = 32'd0;
                        cnt_next   = 6'd0;
                        which_next = 1'b1;
                        state_next = FR_DIV_LO;
                    end
                    else
                    begin
                        cmd_next.last = quo_next;
                        state_next = FR_PUSH;
                    end
                end
            end
            FR_PUSH:
            begin
                cmd_valid = 1'b1;
                if (cmd_ready)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    assign cmd = cmd_reg;

endmodule

### hdl/swph_queue.sv
module swph_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  swph_pkg::cmd_t wr_data,
    input  logic           wr_valid,
    output logic           wr_ready,
    output swph_pkg::cmd_t rd_data,
    output logic           rd_valid,
    input  logic           rd_ready
);
    import swph_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count");
`endif

endmodule

### hdl/swph_back.sv
module swph_back #(
    parameter int NUM_WINDOWS   = 4096,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swph_pkg::cmd_t      cmd,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    output swph_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready
);
    import swph_pkg::*;

    localparam int CW    = $clog2(NUM_WINDOWS);
    localparam int Depth = NUM_WINDOWS * CellSlots;
    localparam int AW    = $clog2(Depth);
    localparam logic [COUNTER_WIDTH-1:0] CntMax = '1;

    logic [COUNTER_WIDTH-1:0] cnt_mem [Depth];
    logic                     tch_mem [NUM_WINDOWS];

    back_state_t              state_reg, state_next;
    logic [AW:0]              clr_reg, clr_next;
    logic [31:0]              k_reg, k_next;
    logic [1:0]               g_reg, g_next;
    cmd_t                     c_reg, c_next;
    out_item_t                o_reg, o_next;
    logic [COUNTER_WIDTH-1:0] rd_reg;
    logic                     tch_rd_reg;
    logic [31:0]              last_c;
    logic [4:0]               off;
    logic [AW-1:0]            addr;
    logic                     mem_we, tch_we;
    logic [COUNTER_WIDTH-1:0] mem_wd;
    logic [CW-1:0]            win_idx;

    assign last_c = (c_reg.last >= 32'(NUM_WINDOWS)) ? 32'(NUM_WINDOWS - 1) : c_reg.last;
    assign off = c_reg.is_read ? ((c_reg.read_group == 2'd0) ? {2'b00, c_reg.read_slot} :
                 5'd2 + 5'({c_reg.read_group - 2'd1, 3'b000}) + 5'(c_reg.read_slot)) :
                 (g_reg == 2'd0) ? c_reg.off0 : (g_reg == 2'd1) ? c_reg.off1 : c_reg.off2;
    assign win_idx = c_reg.is_read ? CW'(c_reg.read_cell) : k_reg[CW-1:0];
    assign addr = (state_reg == BK_CLEAR) ? clr_reg[AW-1:0] :
                  AW'(win_idx) * AW'(CellSlots) + AW'(off);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        g_reg <= g_next;
        c_reg <= c_next;
        o_reg <= o_next;
        rd_reg <= cnt_mem[addr];
        tch_rd_reg <= tch_mem[win_idx];
        if (mem_we)
        begin
            cnt_mem[addr] <= mem_wd;
        end
        if (tch_we)
        begin
            tch_mem[(state_reg == BK_CLEAR) ? clr_reg[CW-1:0] : win_idx] <=
                (state_reg != BK_CLEAR);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        c_next     = c_reg;
        o_next     = o_reg;
        cmd_ready  = 1'b0;
        out_valid  = 1'b0;
        mem_we     = 1'b0;
        tch_we     = 1'b0;
        mem_wd     = (rd_reg == CntMax) ? rd_reg : rd_reg + COUNTER_WIDTH'(1);
        unique case (state_reg)
            BK_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wd = '0;
                tch_we = (clr_reg < (AW+1)'(NUM_WINDOWS));
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'(Depth - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    c_next = cmd;
                    k_next = cmd.first;
                    g_next = 2'd0;
                    if (cmd.is_read)
                    begin
                        state_next = BK_RD;
                    end
                    else if (cmd.first <= ((cmd.last >= 32'(NUM_WINDOWS)) ?
                             32'(NUM_WINDOWS - 1) : cmd.last))
                    begin
                        state_next = BK_RD;
                    end
                end
            end
            BK_RD:
            begin
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (c_reg.is_read)
                begin
                    o_next.cell_touched = (32'(c_reg.read_cell) < 32'(NUM_WINDOWS)) &&
                                          tch_rd_reg;
                    o_next.count_value = ((32'(c_reg.read_cell) >= 32'(NUM_WINDOWS)) ||
                        (c_reg.read_group == 2'd0 && c_reg.read_slot > 3'd1)) ? 32'd0 :
                        32'(rd_reg);
                    state_next = BK_OUT;
                end
                else
                begin
                    state_next = BK_WR;
                end
            end
            BK_WR:
            begin
                mem_we = 1'b1;
                tch_we = 1'b1;
                if (c_reg.proper || g_reg == 2'd2)
                begin
                    g_next = 2'd0;
                    k_next = k_reg + 32'd1;
                    state_next = (k_reg >= last_c) ? BK_IDLE : BK_RD;
                end
                else
                begin
                    g_next = g_reg + 2'd1;
                    state_next = BK_RD;
                end
            end
            BK_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_item = o_reg;

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> state_reg == BK_IDLE) else $error("command taken while busy");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_WR |-> k_reg <= last_c) else $error("window walk past end");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(o_reg)) else $error("result lost");
`endif

endmodule

### hdl/sliding_window_pair_histogram_top.sv
// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_ready    in_item (swph_pkg::in_item_t)
// out       out        out_valid / out_ready  out_item (swph_pkg::out_item_t)
// cfg       in         cfg_we                 cfg_index, cfg_data
// An add runs through the front divider (two 32-step serial divisions),
// then touches each counter in the back by memory read, wait and write.
// A read skips the divider; in the back it passes BK_RD and BK_WAIT, and its result is shown in BK_OUT.
// After reset the back clears the counter memory, all NUM_WINDOWS*26 counters.
// A two-entry queue parts front and back; each side stalls on its own.
module sliding_window_pair_histogram_top #(
    parameter int NUM_WINDOWS   = 4096,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swph_pkg::in_item_t  in_item,
    input  logic                in_valid,
    output logic                in_ready,
    output swph_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    import swph_pkg::*;

    logic [15:0] win_reg, step_reg;
    cmd_t        f_cmd, b_cmd;
    logic        f_valid, f_ready, b_valid, b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= 16'd600;
            step_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW: win_reg  <= cfg_data;
                CFG_STEP:   step_reg <= cfg_data;
                default:    win_reg  <= win_reg;
            endcase
        end
    end

    swph_front u_front (
        .clk, .rst_n, .in_item, .in_valid, .in_ready,
        .window_length(win_reg), .step_length(step_reg),
        .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
    );

    swph_queue u_queue (
        .clk, .rst_n, .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(b_cmd), .rd_valid(b_valid), .rd_ready(b_ready)
    );

    swph_back #(.NUM_WINDOWS(NUM_WINDOWS), .COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
        .clk, .rst_n, .cmd(b_cmd), .cmd_valid(b_valid), .cmd_ready(b_ready),
        .out_item, .out_valid, .out_ready
    );

endmodule
